// ===== rtl/refract_direction_2d_defines.svh =====
// ----------------------------------------------------------------------------
// refract_direction_2d_defines
// assertion macros shared by the refraction block
// ----------------------------------------------------------------------------
`ifndef REFRACT_DIRECTION_2D_DEFINES_SVH
`define REFRACT_DIRECTION_2D_DEFINES_SVH

`ifndef SYNTHESIS
`define RFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg
// types, constants and rounding helpers for the refraction block
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

	localparam int FRAC_BITS = 14;
	localparam int VW = 16;
	localparam int IW = 16;
	localparam int PW = 2 * VW + 1;
	localparam int MW = 2 * VW + IW;
	localparam int SW = FRAC_BITS + 1;
	localparam int DW = 2 * FRAC_BITS + 1;
	localparam int AW = 4;
	localparam int DATA_W = 32;

	localparam logic signed [VW-1:0] ONE = VW'(1 << FRAC_BITS);

	localparam logic [1:0] REG_NORMAL_X = 2'd0;
	localparam logic [1:0] REG_NORMAL_Y = 2'd1;
	localparam logic [1:0] REG_INDEX_FIRST = 2'd2;
	localparam logic [1:0] REG_INDEX_SECOND = 2'd3;

	localparam logic signed [VW-1:0] NORMAL_X_RST = '0;
	localparam logic signed [VW-1:0] NORMAL_Y_RST = ONE;
	localparam logic [IW-1:0] INDEX_RST = IW'(4096);

	typedef struct packed {
		logic signed [VW-1:0] ox;
		logic signed [VW-1:0] oy;
		logic dot_neg;
		logic cross_pos;
		logic cross_neg;
	} side_t;

	typedef struct packed {
		logic signed [VW-1:0] g;
		logic refl;
		side_t side;
	} sq_pay_t;

	typedef struct packed {
		logic signed [VW-1:0] dir_x;
		logic signed [VW-1:0] dir_y;
		logic refl;
	} out_t;

	// round half away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
		input int unsigned sh);
		logic neg;
		logic [63:0] m;
		neg = x[63];
		m = neg ? 64'(-x) : 64'(x);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return neg ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic signed [VW-1:0] sat16(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd32767;
		lo = -64'sd32768;
		if (x > hi) begin
			return VW'(hi);
		end else if (x < lo) begin
			return VW'(lo);
		end
		return VW'(x);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rfd_if.sv =====
// ----------------------------------------------------------------------------
// rfd_if
// valid/ready channels for incoming and outgoing direction words
// ----------------------------------------------------------------------------
`default_nettype none

interface rfd_in_if;
	logic valid;
	logic ready;
	logic signed [rfd_pkg::VW-1:0] in_dir_x;
	logic signed [rfd_pkg::VW-1:0] in_dir_y;
	modport source(output valid, output in_dir_x, output in_dir_y, input ready);
	modport sink(input valid, input in_dir_x, input in_dir_y, output ready);
endinterface

interface rfd_out_if;
	logic valid;
	logic ready;
	logic signed [rfd_pkg::VW-1:0] out_dir_x;
	logic signed [rfd_pkg::VW-1:0] out_dir_y;
	logic reflected;
	modport source(output valid, output out_dir_x, output out_dir_y, output reflected,
		input ready);
	modport sink(input valid, input out_dir_x, input out_dir_y, input reflected,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/refract_direction_2d.sv =====
// ----------------------------------------------------------------------------
// refract_direction_2d
// 2d refraction of a unit ray direction at a flat boundary
// ----------------------------------------------------------------------------
// One direction word enters per cycle while the output queue has room, and one
// result word leaves per cycle while the output side is ready. A word passes
// four front stages, a 48-stage divider for the index ratio, two stages, a
// 15-stage square root, five back stages and the two-entry output queue. The
// whole pipeline advances while the output queue has room; it takes new words
// while results wait in the queue. The user must write registers over the APB
// port only while no word is in flight; the block does not enforce it.
`default_nettype none
`include "refract_direction_2d_defines.svh"

module refract_direction_2d (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	rfd_in_if.sink                            din,
	rfd_out_if.source                         dout,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rfd_pkg::AW-1:0]       paddr,
	input  wire logic [rfd_pkg::DATA_W-1:0]   pwdata,
	output logic [rfd_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	localparam int F = rfd_pkg::FRAC_BITS;
	localparam int VW = rfd_pkg::VW;
	localparam int IW = rfd_pkg::IW;
	localparam int PW = rfd_pkg::PW;
	localparam int MW = rfd_pkg::MW;
	localparam int SW = rfd_pkg::SW;
	localparam int DW = rfd_pkg::DW;
	localparam int XW = PW + VW;
	localparam int FW = PW + 2;

	// configuration
	logic signed [VW-1:0] nx_q;
	logic signed [VW-1:0] ny_q;
	logic [IW-1:0]        idx1_q;
	logic [IW-1:0]        idx2_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= rfd_pkg::NORMAL_X_RST;
			ny_q <= rfd_pkg::NORMAL_Y_RST;
			idx1_q <= rfd_pkg::INDEX_RST;
			idx2_q <= rfd_pkg::INDEX_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				rfd_pkg::REG_NORMAL_X: nx_q <= pwdata[VW-1:0];
				rfd_pkg::REG_NORMAL_Y: ny_q <= pwdata[VW-1:0];
				rfd_pkg::REG_INDEX_FIRST: idx1_q <= pwdata[IW-1:0];
				rfd_pkg::REG_INDEX_SECOND: idx2_q <= pwdata[IW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rfd_pkg::REG_NORMAL_X: prdata = {{(rfd_pkg::DATA_W-VW){1'b0}}, nx_q};
			rfd_pkg::REG_NORMAL_Y: prdata = {{(rfd_pkg::DATA_W-VW){1'b0}}, ny_q};
			rfd_pkg::REG_INDEX_FIRST: prdata = {{(rfd_pkg::DATA_W-IW){1'b0}}, idx1_q};
			rfd_pkg::REG_INDEX_SECOND: prdata = {{(rfd_pkg::DATA_W-IW){1'b0}}, idx2_q};
			default: prdata = '0;
		endcase
	end

	// pipeline control
	logic [1:0] cnt_q;
	logic       en;
	logic       acc;

	assign en = cnt_q != 2'd2;
	assign din.ready = en;
	assign acc = din.valid && din.ready;

	// s1: products
	logic                   vld_s1;
	logic signed [VW-1:0]   vx_s1, vy_s1;
	logic signed [2*VW-1:0] pxx_s1, pyy_s1, pxy_s1, pyx_s1;

	// s2: dot and cross
	logic                   vld_s2;
	logic signed [VW-1:0]   vx_s2, vy_s2;
	logic signed [PW-1:0]   dot_s2, cross_s2;

	// s3: dividend and reflection products
	logic                   vld_s3;
	logic signed [VW-1:0]   vx_s3, vy_s3;
	logic [MW-1:0]          num_s3;
	logic [IW-1:0]          den_s3;
	logic signed [XW-1:0]   rx_s3, ry_s3;
	logic                   dneg_s3, cpos_s3, cneg_s3;

	// s4: reflected direction
	logic                   vld_s4;
	logic [MW-1:0]          num_s4;
	logic [IW-1:0]          den_s4;
	rfd_pkg::side_t         side_s4;

	logic                   div_vld;
	logic [MW-1:0]          div_quo;
	rfd_pkg::side_t         div_side;

	logic                   dot_pos_c;
	logic [IW-1:0]          ni_c, nf_c;
	logic [2*VW-1:0]        cmag_c;

	always_comb begin
		dot_pos_c = dot_s2 > 0;
		ni_c = dot_pos_c ? idx2_q : idx1_q;
		nf_c = dot_pos_c ? idx1_q : idx2_q;
		if (nf_c == '0) begin
			nf_c = IW'(1);
		end
		cmag_c = cross_s2[PW-1] ? (2*VW)'(-cross_s2) : (2*VW)'(cross_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1 <= din.in_dir_x;
			vy_s1 <= din.in_dir_y;
			pxx_s1 <= din.in_dir_x * nx_q;
			pyy_s1 <= din.in_dir_y * ny_q;
			pxy_s1 <= nx_q * din.in_dir_y;
			pyx_s1 <= ny_q * din.in_dir_x;

			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			dot_s2 <= PW'(pxx_s1) + PW'(pyy_s1);
			cross_s2 <= PW'(pxy_s1) - PW'(pyx_s1);

			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
			num_s3 <= MW'(cmag_c) * MW'(ni_c);
			den_s3 <= nf_c;
			rx_s3 <= XW'(dot_s2) * XW'(nx_q);
			ry_s3 <= XW'(dot_s2) * XW'(ny_q);
			dneg_s3 <= dot_s2 < 0;
			cpos_s3 <= cross_s2 > 0;
			cneg_s3 <= cross_s2 < 0;

			num_s4 <= num_s3;
			den_s4 <= den_s3;
			side_s4.ox <= rfd_pkg::sat16(64'(vx_s3) - rfd_pkg::rnd_shift(64'(rx_s3), 2*F - 1));
			side_s4.oy <= rfd_pkg::sat16(64'(vy_s3) - rfd_pkg::rnd_shift(64'(ry_s3), 2*F - 1));
			side_s4.dot_neg <= dneg_s3;
			side_s4.cross_pos <= cpos_s3;
			side_s4.cross_neg <= cneg_s3;
		end
	end

	rfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_num   (num_s4),
		.in_den   (den_s4),
		.in_side  (side_s4),
		.out_vld  (div_vld),
		.out_quo  (div_quo),
		.out_side (div_side)
	);

	// s5: rounded gamma, s6: radicand
	logic                   vld_s5, vld_s6;
	logic signed [VW-1:0]   g_s5;
	logic [SW-1:0]          agm_s5;
	logic                   refl_s5;
	rfd_pkg::side_t         side_s5;
	logic [DW-1:0]          rad_s6;
	rfd_pkg::sq_pay_t       pay_s6;

	logic [MW:0]            ag_c;
	logic signed [VW-1:0]   gmag_c;

	always_comb begin
		ag_c = ({1'b0, div_quo} + (MW+1)'(1 << (F - 1))) >> F;
		gmag_c = signed'(VW'(ag_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s5 <= div_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			refl_s5 <= ag_c > (MW+1)'(rfd_pkg::ONE);
			g_s5 <= div_side.cross_neg ? -gmag_c : gmag_c;
			agm_s5 <= ag_c[SW-1:0];
			side_s5 <= div_side;

			rad_s6 <= DW'((DW'(1) << (2*F)) - DW'(agm_s5) * DW'(agm_s5));
			pay_s6.g <= g_s5;
			pay_s6.refl <= refl_s5;
			pay_s6.side <= side_s5;
		end
	end

	logic                   sq_vld;
	logic [SW-1:0]          sq_root;
	rfd_pkg::sq_pay_t       sq_pay;

	rfd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.in_rad   (rad_s6),
		.in_pay   (pay_s6),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_pay  (sq_pay)
	);

	// s7..s11: refracted direction and root choice
	logic                   vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	logic signed [2*VW-1:0] m1_s7, m2_s7, m3_s7, m4_s7;
	logic signed [PW-1:0]   wx_s8, wy_s8;
	logic signed [2*VW-1:0] dt0_s8, dt1_s8;
	logic signed [PW-1:0]   wx_s9, wy_s9;
	logic signed [2*VW-1:0] dt0_s9, dt1_s9;
	logic signed [XW-1:0]   pa_s9, pb_s9, pc_s9, pd_s9;
	logic signed [FW-1:0]   fx_s10, fy_s10;
	logic                   refl_s7, refl_s8, refl_s9, refl_s10;
	rfd_pkg::side_t         side_s7, side_s8, side_s9, side_s10;
	rfd_pkg::out_t          out_s11;

	logic signed [VW-1:0]   s_c;
	logic signed [XW:0]     dn_c, dd_c;
	logic                   flip_c;

	always_comb begin
		s_c = signed'(VW'(sq_root));
		dn_c = (XW+1)'(pa_s9) + (XW+1)'(pb_s9);
		dd_c = (XW+1)'(pc_s9) - (XW+1)'(pd_s9);
		flip_c = (side_s9.dot_neg != (dn_c < 0)) || (side_s9.cross_pos != (dd_c < 0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s7 <= sq_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s7 <= ny_q * sq_pay.g;
			m2_s7 <= nx_q * sq_pay.g;
			m3_s7 <= nx_q * s_c;
			m4_s7 <= ny_q * s_c;
			refl_s7 <= sq_pay.refl;
			side_s7 <= sq_pay.side;

			wx_s8 <= PW'(m3_s7) - PW'(m1_s7);
			wy_s8 <= PW'(m2_s7) + PW'(m4_s7);
			dt0_s8 <= m3_s7;
			dt1_s8 <= m4_s7;
			refl_s8 <= refl_s7;
			side_s8 <= side_s7;

			pa_s9 <= XW'(wx_s8) * XW'(nx_q);
			pb_s9 <= XW'(wy_s8) * XW'(ny_q);
			pc_s9 <= XW'(wx_s8) * XW'(ny_q);
			pd_s9 <= XW'(wy_s8) * XW'(nx_q);
			wx_s9 <= wx_s8;
			wy_s9 <= wy_s8;
			dt0_s9 <= dt0_s8;
			dt1_s9 <= dt1_s8;
			refl_s9 <= refl_s8;
			side_s9 <= side_s8;

			fx_s10 <= flip_c ? FW'(wx_s9) - (FW'(dt0_s9) <<< 1) : FW'(wx_s9);
			fy_s10 <= flip_c ? FW'(wy_s9) - (FW'(dt1_s9) <<< 1) : FW'(wy_s9);
			refl_s10 <= refl_s9;
			side_s10 <= side_s9;

			out_s11.dir_x <= refl_s10 ? side_s10.ox
				: rfd_pkg::sat16(rfd_pkg::rnd_shift(64'(fx_s10), F));
			out_s11.dir_y <= refl_s10 ? side_s10.oy
				: rfd_pkg::sat16(rfd_pkg::rnd_shift(64'(fy_s10), F));
			out_s11.refl <= refl_s10;
		end
	end

	// output queue
	rfd_pkg::out_t fifo_q [2];
	logic          wptr_q, rptr_q;
	logic          push, pop;

	assign push = vld_s11 && en;
	assign pop = dout.valid && dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= out_s11;
		end
	end

	assign dout.valid = cnt_q != 2'd0;
	assign dout.out_dir_x = fifo_q[rptr_q].dir_x;
	assign dout.out_dir_y = fifo_q[rptr_q].dir_y;
	assign dout.reflected = fifo_q[rptr_q].refl;

	`RFD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`RFD_ASSERT_NEXT(a_stall_hold, clk, arst_n, !en && !pop, $stable(vld_s11) && $stable(cnt_q))
	`RFD_ASSERT_NEXT(a_accept_enters, clk, arst_n, acc, vld_s1)
	`RFD_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 2'd1)

endmodule

`default_nettype wire

// ===== rtl/rfd_div.sv =====
// ----------------------------------------------------------------------------
// rfd_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire logic [rfd_pkg::MW-1:0]    in_num,
	input  wire logic [rfd_pkg::IW-1:0]    in_den,
	input  wire rfd_pkg::side_t            in_side,
	output logic                           out_vld,
	output logic [rfd_pkg::MW-1:0]         out_quo,
	output rfd_pkg::side_t                 out_side
);

	localparam int MW = rfd_pkg::MW;
	localparam int IW = rfd_pkg::IW;

	logic                vld_s  [MW+1];
	logic [MW-1:0]       nq_s   [MW+1];
	logic [IW-1:0]       rem_s  [MW+1];
	logic [IW-1:0]       den_s  [MW+1];
	rfd_pkg::side_t      side_s [MW+1];

	assign vld_s[0] = in_vld;
	assign nq_s[0] = in_num;
	assign rem_s[0] = '0;
	assign den_s[0] = in_den;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < MW; k++) begin : g_stage
		logic [IW:0] rsh;
		logic [IW:0] rsub;
		logic        ge;

		assign rsh = {rem_s[k], nq_s[k][MW-1]};
		assign ge = rsh >= {1'b0, den_s[k]};
		assign rsub = rsh - {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rsub[IW-1:0] : rsh[IW-1:0];
				nq_s[k+1] <= {nq_s[k][MW-2:0], ge};
				den_s[k+1] <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld = vld_s[MW];
	assign out_quo = nq_s[MW];
	assign out_side = side_s[MW];

endmodule

`default_nettype wire

// ===== rtl/rfd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rfd_sqrt
// pipelined integer square root, one root bit per stage, floor result
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_sqrt (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_vld,
	input  wire logic [rfd_pkg::DW-1:0] in_rad,
	input  wire rfd_pkg::sq_pay_t       in_pay,
	output logic                        out_vld,
	output logic [rfd_pkg::SW-1:0]      out_root,
	output rfd_pkg::sq_pay_t            out_pay
);

	localparam int SW = rfd_pkg::SW;
	localparam int DW = rfd_pkg::DW;
	localparam int RW = DW + 2;

	logic               vld_s [SW+1];
	logic [DW-1:0]      rem_s [SW+1];
	logic [SW-1:0]      res_s [SW+1];
	rfd_pkg::sq_pay_t   pay_s [SW+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = in_rad;
	assign res_s[0] = '0;
	assign pay_s[0] = in_pay;

	for (genvar k = 0; k < SW; k++) begin : g_stage
		localparam int B = SW - 1 - k;
		logic [RW-1:0] delta;
		logic [RW-1:0] rdiff;
		logic          ge;

		assign delta = (RW'(res_s[k]) << (B + 1)) + (RW'(1) << (2 * B));
		assign ge = RW'(rem_s[k]) >= delta;
		assign rdiff = RW'(rem_s[k]) - delta;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rdiff[DW-1:0] : rem_s[k];
				res_s[k+1] <= ge ? (res_s[k] | (SW'(1) << B)) : res_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_vld = vld_s[SW];
	assign out_root = res_s[SW];
	assign out_pay = pay_s[SW];

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 2d refraction block
// ----------------------------------------------------------------------------
// Directions go in over a valid/ready channel, and the boundary is set over
// the apb port between phases while nothing is in flight. Every accepted word
// is run through a local fixed point model of the refraction. The expected
// result is queued and compared field by field with the next result word.
// Directed words cover the field extremes, a zero dot product, total internal
// reflection and a zero final index. Random phases follow with idling on both
// sides and one long output hold-off. The last phase runs without idling.
`timescale 1ns / 1ps

module tb_top;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rfd_pkg::AW-1:0] paddr;
	logic [rfd_pkg::DATA_W-1:0] pwdata;
	logic [rfd_pkg::DATA_W-1:0] prdata;
	logic pready;

	rfd_in_if dir_in ();
	rfd_out_if dir_out ();

	refract_direction_2d dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(dir_in.sink),
		.dout(dir_out.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// boundary as the block should hold it
	longint bnd_nx;
	longint bnd_ny;
	longint bnd_idx1;
	longint bnd_idx2;

	rfd_pkg::out_t exp_dirs[$];
	int errors;
	bit idle_on;
	int hold_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint round_away(input longint x, input int sh);
		longint unsigned m;
		m = (x < 0) ? longint'(-x) : x;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [15:0] clamp_q(input longint x);
		if (x > 32767) begin
			return 16'sh7fff;
		end else if (x < -32768) begin
			return 16'sh8000;
		end
		return 16'(x);
	endfunction

	function automatic longint int_sqrt(input longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic rfd_pkg::out_t refract(input logic signed [15:0] in_x,
		input logic signed [15:0] in_y);
		longint vx, vy, nx, ny, unit, dot, ni, nf, crs, gam, g, ag, s;
		longint t0, t1, dd_in, wx, wy, dn_out, dd_out;
		rfd_pkg::out_t r;
		vx = in_x;
		vy = in_y;
		nx = bnd_nx;
		ny = bnd_ny;
		unit = 64'sd1 << rfd_pkg::FRAC_BITS;
		dot = vx * nx + vy * ny;
		if (dot > 0) begin
			ni = bnd_idx2;
			nf = bnd_idx1;
		end else begin
			ni = bnd_idx1;
			nf = bnd_idx2;
		end
		if (nf == 0) nf = 1;
		crs = nx * vy - ny * vx;
		gam = (crs * ni) / nf;
		g = round_away(gam, rfd_pkg::FRAC_BITS);
		ag = (g < 0) ? -g : g;
		if (ag > unit) begin
			r.dir_x = clamp_q(vx - round_away(2 * dot * nx, 2 * rfd_pkg::FRAC_BITS));
			r.dir_y = clamp_q(vy - round_away(2 * dot * ny, 2 * rfd_pkg::FRAC_BITS));
			r.refl = 1'b1;
			return r;
		end
		s = int_sqrt((64'd1 << (2 * rfd_pkg::FRAC_BITS)) - ag * ag);
		t0 = nx * s;
		t1 = ny * s;
		dd_in = vx * ny - vy * nx;
		wx = -ny * g + t0;
		wy = nx * g + t1;
		dn_out = wx * nx + wy * ny;
		dd_out = wx * ny - wy * nx;
		if (((dot < 0) != (dn_out < 0)) || ((dd_in < 0) != (dd_out < 0))) begin
			wx -= 2 * t0;
			wy -= 2 * t1;
		end
		r.dir_x = clamp_q(round_away(wx, rfd_pkg::FRAC_BITS));
		r.dir_y = clamp_q(round_away(wy, rfd_pkg::FRAC_BITS));
		r.refl = 1'b0;
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		rfd_pkg::out_t want;
		if (arst_n && dir_out.valid && dir_out.ready) begin
			if (exp_dirs.size() == 0) begin
				report("unexpected word", 1, 0);
			end else begin
				want = exp_dirs.pop_front();
				if (dir_out.out_dir_x !== want.dir_x) report("out_dir_x", dir_out.out_dir_x, want.dir_x);
				if (dir_out.out_dir_y !== want.dir_y) report("out_dir_y", dir_out.out_dir_y, want.dir_y);
				if (dir_out.reflected !== want.refl) report("reflected", dir_out.reflected, want.refl);
			end
		end
	end

	// output side ready, with idle bursts and long hold-offs
	always begin
		int n;
		@(negedge clk);
		if (hold_cycles > 0) begin
			dir_out.ready <= 1'b0;
			hold_cycles--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 19);
			dir_out.ready <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end else begin
			dir_out.ready <= 1'b1;
		end
	end

	// entered and left at a falling edge
	task automatic send_dir(input logic signed [15:0] x, input logic signed [15:0] y);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			dir_in.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		dir_in.valid <= 1'b1;
		dir_in.in_dir_x <= x;
		dir_in.in_dir_y <= y;
		do @(posedge clk); while (!dir_in.ready);
		exp_dirs.insert(exp_dirs.size(), refract(x, y));
		@(negedge clk);
	endtask

	task automatic drain();
		dir_in.valid <= 1'b0;
		while (exp_dirs.size() != 0) @(negedge clk);
		repeat (90) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= rfd_pkg::AW'(4 * idx);
		pwdata <= rfd_pkg::DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rfd_pkg::REG_NORMAL_X: begin
				bnd_nx = longint'($signed(val));
			end
			rfd_pkg::REG_NORMAL_Y: begin
				bnd_ny = longint'($signed(val));
			end
			rfd_pkg::REG_INDEX_FIRST: begin
				bnd_idx1 = val;
			end
			default: begin
				bnd_idx2 = val;
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata[15:0] !== val) report("readback", prdata[15:0], val);
	endtask

	task automatic set_boundary(input logic [15:0] nx, input logic [15:0] ny,
		input logic [15:0] i1, input logic [15:0] i2);
		drain();
		apb_write(rfd_pkg::REG_NORMAL_X, nx);
		apb_write(rfd_pkg::REG_NORMAL_Y, ny);
		apb_write(rfd_pkg::REG_INDEX_FIRST, i1);
		apb_write(rfd_pkg::REG_INDEX_SECOND, i2);
	endtask

	task automatic rand_dir(output logic signed [15:0] x, output logic signed [15:0] y);
		int mode;
		longint a, b;
		logic signed [15:0] picks[5];
		picks = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh4000, 16'shc000};
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			a = longint'($urandom_range(0, 32768)) - 16384;
			b = int_sqrt((64'd1 << 28) - a * a) + longint'($urandom_range(0, 4)) - 2;
			x = 16'(a);
			y = $urandom_range(0, 1) ? 16'(b) : 16'(-b);
		end else if (mode < 9) begin
			x = 16'($urandom);
			y = 16'($urandom);
		end else begin
			x = picks[$urandom_range(0, 4)];
			y = picks[$urandom_range(0, 4)];
		end
	endtask

	task automatic rand_unit_normal(output logic [15:0] nx, output logic [15:0] ny);
		longint a, b;
		a = longint'($urandom_range(0, 32768)) - 16384;
		b = int_sqrt((64'd1 << 28) - a * a);
		nx = 16'(a);
		ny = $urandom_range(0, 1) ? 16'(b) : 16'(-b);
	endtask

	task automatic send_random(input int count);
		logic signed [15:0] x, y;
		repeat (count) begin
			rand_dir(x, y);
			send_dir(x, y);
		end
	endtask

	task automatic test_directed();
		// reset boundary: extremes, zero dot, both sides
		send_dir(16'sh0000, 16'sh4000);
		send_dir(16'sh0000, 16'shc000);
		send_dir(16'sh4000, 16'sh0000);
		send_dir(16'sh0000, 16'sh0000);
		send_dir(16'sh7fff, 16'sh7fff);
		send_dir(16'sh8000, 16'sh8000);
		send_dir(16'sh7fff, 16'sh8000);
		send_dir(16'sh8000, 16'sh7fff);
		send_dir(16'sh2d41, 16'shd2bf);
		// dense side first: grazing rays reflect
		set_boundary(16'sh2d41, 16'sh2d41, 16'd6144, 16'd4096);
		send_dir(16'sh2d41, 16'shd2bf);
		send_dir(16'shd2bf, 16'sh2d41);
		send_dir(16'sh3f00, 16'shf000);
		send_dir(16'shc000, 16'sh0400);
		send_dir(16'sh0000, 16'shc000);
		send_dir(16'sh7fff, 16'sh8000);
		// zero final index
		set_boundary(16'sh0000, 16'sh4000, 16'd4096, 16'd0);
		send_dir(16'sh0000, 16'shc000);
		send_dir(16'sh0001, 16'shc000);
		send_dir(16'sh0000, 16'sh4000);
		// extreme normal and indices
		set_boundary(16'sh8000, 16'sh7fff, 16'd65535, 16'd1);
		send_dir(16'sh0001, 16'sh0001);
		send_dir(16'sh4000, 16'sh0000);
		send_dir(16'sh8000, 16'sh8000);
		set_boundary(16'sh4000, 16'sh0000, 16'd1, 16'd65535);
		send_dir(16'sh2d41, 16'sh2d41);
		send_dir(16'shd2bf, 16'sh2d41);
	endtask

	task automatic test_phases();
		logic [15:0] nx, ny;
		set_boundary(16'shc000, 16'sh0000, 16'd4096, 16'd6144);
		send_random(150);
		set_boundary(16'sh2d41, 16'shd2bf, 16'd6144, 16'd4096);
		send_random(150);
		set_boundary(16'sh0000, 16'shc000, 16'd65535, 16'd1);
		send_random(100);
		set_boundary(16'sh7fff, 16'sh8000, 16'd1, 16'd65535);
		send_random(100);
		repeat (3) begin
			rand_unit_normal(nx, ny);
			set_boundary(nx, ny, 16'($urandom_range(2048, 12288)),
				16'($urandom_range(2048, 12288)));
			send_random(100);
		end
	endtask

	task automatic test_backpressure();
		set_boundary(16'sh0000, 16'sh4000, 16'd5000, 16'd4096);
		hold_cycles = 400;
		send_random(150);
	endtask

	task automatic test_streaming();
		set_boundary(16'shd2bf, 16'shd2bf, 16'd4096, 16'd5461);
		idle_on = 1'b0;
		send_random(150);
	endtask

	initial begin
		errors = 0;
		idle_on = 1'b1;
		hold_cycles = 0;
		bnd_nx = 0;
		bnd_ny = 64'sd1 << rfd_pkg::FRAC_BITS;
		bnd_idx1 = 4096;
		bnd_idx2 = 4096;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		dir_in.valid = 1'b0;
		dir_in.in_dir_x = '0;
		dir_in.in_dir_y = '0;
		dir_out.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_phases();
		test_backpressure();
		test_streaming();
		drain();
		if (errors == 0) begin
			$display("refract_direction_2d test passed");
		end else begin
			$display("refract_direction_2d test failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("refract_direction_2d test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rfd_pkg.sv
rtl/rfd_if.sv
rtl/rfd_div.sv
rtl/rfd_sqrt.sv
rtl/refract_direction_2d.sv
tb/tb_top.sv
